// ===== rtl/core/tlmp_pkg.sv =====
// ----------------------------------------------------------------------------
// tlmp_pkg - telnet line-mode parser package
// Byte codes, parse phases, result encodings and the types shared between
// the step decoder and the top level.
// ----------------------------------------------------------------------------
package tlmp_pkg;

  // Telnet and control byte codes
  localparam logic [7:0] B_IAC   = 8'd255;
  localparam logic [7:0] B_DONT  = 8'd254;
  localparam logic [7:0] B_DO    = 8'd253;
  localparam logic [7:0] B_WONT  = 8'd252;
  localparam logic [7:0] B_WILL  = 8'd251;
  localparam logic [7:0] B_SB    = 8'd250;
  localparam logic [7:0] B_SE    = 8'd240;
  localparam logic [7:0] B_IP    = 8'd244;
  localparam logic [7:0] B_SUSP  = 8'd237;
  localparam logic [7:0] B_EOF   = 8'd236;
  localparam logic [7:0] B_NAWS  = 8'd31;
  localparam logic [7:0] B_TMARK = 8'd6;
  localparam logic [7:0] B_ECHO  = 8'd1;
  localparam logic [7:0] B_SGA   = 8'd3;
  localparam logic [7:0] B_DC3   = 8'd19;
  localparam logic [7:0] B_CR    = 8'd13;
  localparam logic [7:0] B_LF    = 8'd10;
  localparam logic [7:0] B_EOT   = 8'd4;
  localparam logic [7:0] B_ETX   = 8'd3;
  localparam logic [7:0] B_NUL   = 8'd0;

  // Parse phases
  localparam logic [3:0] PH_NORMAL   = 4'd0;
  localparam logic [3:0] PH_CR       = 4'd1;
  localparam logic [3:0] PH_IAC      = 4'd2;
  localparam logic [3:0] PH_VERB     = 4'd3;
  localparam logic [3:0] PH_SB       = 4'd4;
  localparam logic [3:0] PH_NAWS     = 4'd5;
  localparam logic [3:0] PH_TAIL1    = 4'd6;
  localparam logic [3:0] PH_TAIL2    = 4'd7;
  localparam logic [3:0] PH_SKIP     = 4'd8;
  localparam logic [3:0] PH_SKIP_IAC = 4'd9;

  // Result kinds
  localparam logic [1:0] K_DATA = 2'd0;
  localparam logic [1:0] K_TX   = 2'd1;
  localparam logic [1:0] K_EVT  = 2'd2;
  localparam logic [1:0] K_WIN  = 2'd3;

  // Event codes
  localparam logic [1:0] EV_LINE  = 2'd0;
  localparam logic [1:0] EV_INTR  = 2'd1;
  localparam logic [1:0] EV_SUSP  = 2'd2;
  localparam logic [1:0] EV_CLOSE = 2'd3;

  localparam logic [2:0] NAWS_BYTES = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [1:0]  event_code;
    logic [15:0] win_width;
    logic [15:0] win_height;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [3:0]  phase;
    logic [7:0]  pending_verb;
    logic [2:0]  naws_count;
    logic        naws_escape;
    logic [31:0] naws_shift;
    logic        line_has_data;
  } state_t;

  // Results of one byte: count plus up to three entries, entry 0 first
  typedef struct packed {
    logic [1:0]       n;
    result_t [2:0]    r;
  } burst_t;

  function automatic result_t mk_res(logic [1:0] kind, logic [7:0] data,
                                     logic [1:0] ev, logic [31:0] win);
    result_t r;
    r.kind       = kind;
    r.data_byte  = data;
    r.event_code = ev;
    r.win_width  = win[31:16];
    r.win_height = win[15:0];
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/core/tlmp_if.sv =====
// ----------------------------------------------------------------------------
// tlmp_if - channel interfaces of the telnet line-mode parser
// Valid/ready channels for received bytes and for parser results.
// ----------------------------------------------------------------------------
interface tlmp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tlmp_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [1:0]  event_code;
  logic [15:0] win_width;
  logic [15:0] win_height;
  logic        last;

  modport source (output valid, output kind, output data_byte, output event_code,
                  output win_width, output win_height, output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input event_code,
                  input win_width, input win_height, input last, output ready);
endinterface

// ===== rtl/core/tlmp_step.sv =====
// ----------------------------------------------------------------------------
// tlmp_step - one-byte parse step
// From the parser state and one received byte, forms the next state and the
// up to three results that the byte causes.
// ----------------------------------------------------------------------------
module tlmp_step (
  input  tlmp_pkg::state_t st,
  input  logic [7:0]       rx_byte,
  output tlmp_pkg::state_t nxt,
  output tlmp_pkg::burst_t burst
);
  import tlmp_pkg::*;

  logic [2:0] cnt_inc;

  assign cnt_inc = st.naws_count + 3'd1;

  always_comb begin
    nxt        = st;
    burst.n    = 2'd0;
    burst.r[0] = mk_res(K_DATA, B_NUL, EV_LINE, 32'd0);
    burst.r[1] = burst.r[0];
    burst.r[2] = burst.r[0];

    case (st.phase)
      PH_NORMAL: begin
        if (rx_byte == B_IAC) begin
          nxt.phase = PH_IAC;
        end else if (rx_byte == B_LF) begin
          burst.n    = 2'd3;
          burst.r[0] = mk_res(K_DATA, B_CR, EV_LINE, 32'd0);
          burst.r[1] = mk_res(K_DATA, B_LF, EV_LINE, 32'd0);
          burst.r[2] = mk_res(K_EVT, B_NUL, EV_LINE, 32'd0);
          nxt.line_has_data = 1'b0;
        end else if (rx_byte == B_CR) begin
          nxt.phase = PH_CR;
        end else if (rx_byte == B_EOT) begin
          if (!st.line_has_data) begin
            burst.n    = 2'd1;
            burst.r[0] = mk_res(K_EVT, B_NUL, EV_CLOSE, 32'd0);
          end
        end else if (rx_byte == B_ETX || rx_byte == B_DC3) begin
          burst.n    = 2'd3;
          burst.r[0] = mk_res(K_TX, B_CR, EV_LINE, 32'd0);
          burst.r[1] = mk_res(K_TX, B_LF, EV_LINE, 32'd0);
          burst.r[2] = mk_res(K_EVT, B_NUL,
                              (rx_byte == B_ETX) ? EV_INTR : EV_SUSP, 32'd0);
          nxt.line_has_data = 1'b0;
        end else begin
          burst.n    = 2'd1;
          burst.r[0] = mk_res(K_DATA, rx_byte, EV_LINE, 32'd0);
          nxt.line_has_data = 1'b1;
        end
      end
      PH_CR: begin
        nxt.phase = PH_NORMAL;
        if (rx_byte == B_NUL || rx_byte == B_LF) begin
          burst.n    = 2'd3;
          burst.r[0] = mk_res(K_DATA, B_CR, EV_LINE, 32'd0);
          burst.r[1] = mk_res(K_DATA, B_LF, EV_LINE, 32'd0);
          burst.r[2] = mk_res(K_EVT, B_NUL, EV_LINE, 32'd0);
          nxt.line_has_data = 1'b0;
        end else begin
          // lone CR: keep it, then the byte raw
          burst.n    = 2'd2;
          burst.r[0] = mk_res(K_DATA, B_CR, EV_LINE, 32'd0);
          burst.r[1] = mk_res(K_DATA, rx_byte, EV_LINE, 32'd0);
          nxt.line_has_data = 1'b1;
        end
      end
      PH_IAC: begin
        nxt.phase = PH_NORMAL;
        if (rx_byte >= B_WILL && rx_byte <= B_DONT) begin
          nxt.pending_verb = rx_byte;
          nxt.phase        = PH_VERB;
        end else if (rx_byte == B_SB) begin
          nxt.phase = PH_SB;
        end else if (rx_byte == B_IP || rx_byte == B_SUSP) begin
          burst.n    = 2'd3;
          burst.r[0] = mk_res(K_TX, B_CR, EV_LINE, 32'd0);
          burst.r[1] = mk_res(K_TX, B_LF, EV_LINE, 32'd0);
          burst.r[2] = mk_res(K_EVT, B_NUL,
                              (rx_byte == B_IP) ? EV_INTR : EV_SUSP, 32'd0);
          nxt.line_has_data = 1'b0;
        end else if (rx_byte == B_EOF) begin
          if (!st.line_has_data) begin
            burst.n    = 2'd1;
            burst.r[0] = mk_res(K_EVT, B_NUL, EV_CLOSE, 32'd0);
          end
        end else if (rx_byte == B_IAC) begin
          burst.n    = 2'd1;
          burst.r[0] = mk_res(K_DATA, B_IAC, EV_LINE, 32'd0);
          nxt.line_has_data = 1'b1;
        end
      end
      PH_VERB: begin
        nxt.phase  = PH_NORMAL;
        burst.r[0] = mk_res(K_TX, B_IAC, EV_LINE, 32'd0);
        burst.r[2] = mk_res(K_TX, rx_byte, EV_LINE, 32'd0);
        if (rx_byte == B_TMARK) begin
          if (st.pending_verb == B_DO) begin
            burst.n    = 2'd3;
            burst.r[1] = mk_res(K_TX, B_WILL, EV_LINE, 32'd0);
          end
        end else if (rx_byte == B_ECHO) begin
          if (st.pending_verb == B_WILL) begin
            burst.n    = 2'd3;
            burst.r[1] = mk_res(K_TX, B_DONT, EV_LINE, 32'd0);
          end
        end else if (rx_byte == B_SGA || rx_byte == B_NAWS) begin
          burst.n = 2'd0;
        end else if (st.pending_verb == B_DO) begin
          burst.n    = 2'd3;
          burst.r[1] = mk_res(K_TX, B_WONT, EV_LINE, 32'd0);
        end else if (st.pending_verb == B_WILL) begin
          burst.n    = 2'd3;
          burst.r[1] = mk_res(K_TX, B_DONT, EV_LINE, 32'd0);
        end
      end
      PH_SB: begin
        if (rx_byte == B_NAWS) begin
          nxt.phase       = PH_NAWS;
          nxt.naws_count  = 3'd0;
          nxt.naws_escape = 1'b0;
          nxt.naws_shift  = 32'd0;
        end else begin
          nxt.phase = PH_SKIP;
        end
      end
      PH_NAWS: begin
        if (!st.naws_escape && rx_byte == B_IAC) begin
          nxt.naws_escape = 1'b1;
        end else begin
          nxt.naws_escape = 1'b0;
          nxt.naws_shift  = {st.naws_shift[23:0], rx_byte};
          nxt.naws_count  = cnt_inc;
          if (cnt_inc >= NAWS_BYTES) begin
            nxt.phase = PH_TAIL1;
          end
        end
      end
      PH_TAIL1: begin
        nxt.phase = PH_TAIL2;
      end
      PH_TAIL2: begin
        nxt.phase      = PH_NORMAL;
        nxt.naws_count = 3'd0;
        burst.n        = 2'd1;
        burst.r[0]     = mk_res(K_WIN, B_NUL, EV_LINE, st.naws_shift);
      end
      PH_SKIP: begin
        if (rx_byte == B_IAC) begin
          nxt.phase = PH_SKIP_IAC;
        end
      end
      PH_SKIP_IAC: begin
        nxt.phase = (rx_byte == B_SE) ? PH_NORMAL : PH_SKIP;
      end
      default: begin
        nxt.phase = PH_NORMAL;
      end
    endcase

    // flag the final result of this byte
    case (burst.n)
      2'd1:    burst.r[0].last = 1'b1;
      2'd2:    burst.r[1].last = 1'b1;
      2'd3:    burst.r[2].last = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== rtl/core/telnet_line_mode_parser.sv =====
// ----------------------------------------------------------------------------
// telnet_line_mode_parser - telnet receive parser in line mode
// Parses received telnet bytes, answers option requests, decodes NAWS and
// marks line ends and control events.
// ----------------------------------------------------------------------------
// A received byte is taken on rx and parsed in the same cycle against the
// registered parser state; its zero to three results land in a three-entry
// result queue and leave one per cycle while res is ready, through a
// registered res port, each byte's final result flagged with last. Bytes
// yielding no result or a single one stream at one per clock while res is
// ready; a byte with more results holds rx while the queue drains until its
// last result moves out, so the byte rate is set by the single result port.
// Option replies are three transmit results (IAC, verb, option); line ends,
// interrupts and suspends are three results; NAWS gives one window-size
// result after the two trailing bytes. The block needs no clearing pass.
// ----------------------------------------------------------------------------
module telnet_line_mode_parser (
  input  logic     clk,
  input  logic     rst,
  tlmp_rx_if.sink  rx,
  tlmp_res_if.source res
);
  import tlmp_pkg::*;

  // Parser state and its next value from the step logic
  state_t        st;
  state_t        st_next;
  burst_t        dec;

  // Result queue: entry 0 is the head, cnt entries are live
  result_t [2:0] q;
  logic [1:0]    cnt;

  // Output register
  result_t       oreg;
  logic          ov;

  logic          rx_fire;
  logic          move;

  tlmp_step u_step (
    .st      (st),
    .rx_byte (rx.rx_byte),
    .nxt     (st_next),
    .burst   (dec)
  );

  // Advance the queue head into the output register when it is free or
  // being taken this cycle.
  assign move    = (cnt != 2'd0) && (!ov || res.ready);

  // Take a new byte when the queue is empty, or when its last entry moves
  // out this cycle.
  assign rx.ready = (cnt == 2'd0) || ((cnt == 2'd1) && move);
  assign rx_fire  = rx.valid && rx.ready;

  // Parser state: update once per accepted byte.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase         <= PH_NORMAL;
      st.pending_verb  <= 8'd0;
      st.naws_count    <= 3'd0;
      st.naws_escape   <= 1'b0;
      st.naws_shift    <= 32'd0;
      st.line_has_data <= 1'b0;
    end else if (rx_fire) begin
      st <= st_next;
    end
  end

  // Queue count: load on accept, otherwise drop one per move.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (rx_fire) begin
      cnt <= dec.n;
    end else if (move) begin
      cnt <= cnt - 2'd1;
    end
  end

  // Queue payload: load the whole burst on accept, else shift toward the head.
  always_ff @(posedge clk) begin
    if (rx_fire) begin
      q <= dec.r;
    end else if (move) begin
      q[0] <= q[1];
      q[1] <= q[2];
    end
  end

  // Output register: hold until taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (move) begin
      ov <= 1'b1;
    end else if (res.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      oreg <= q[0];
    end
  end

  assign res.valid      = ov;
  assign res.kind       = oreg.kind;
  assign res.data_byte  = oreg.data_byte;
  assign res.event_code = oreg.event_code;
  assign res.win_width  = oreg.win_width;
  assign res.win_height = oreg.win_height;
  assign res.last       = oreg.last;

  // The queue holds exactly what the last accepted byte produced.
  a_burst_load: assert property (@(posedge clk) disable iff (rst)
    rx_fire |=> cnt == $past(dec.n))
    else $error("result queue count does not match accepted burst");

  // No byte is taken while two or more results are still queued.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (cnt == 2'd2 || cnt == 2'd3) |-> !rx.ready)
    else $error("byte accepted over a queued burst");

  // The NAWS counter never passes the four value bytes.
  a_naws_bound: assert property (@(posedge clk) disable iff (rst)
    st.naws_count <= NAWS_BYTES)
    else $error("NAWS byte count out of range");

  // A result that moves into the output register while it is full must be
  // replacing one that is taken.
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (move && ov) |-> res.ready)
    else $error("output register overwritten before taken");

endmodule
